>>> rtl/brf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants of the bitmap rotate/flip block.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int IDX_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int XFORM_W    = 3;
    localparam int FLIP_BIT   = 2;
    localparam int DIV_SHIFT  = 13;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic REG_TRANSFORM = 1'b0;
    localparam logic REQ_LOAD      = 1'b0;

    typedef enum logic [1:0] {
        K_LOAD,
        K_READ,
        K_ZERO
    } t_kind;

    typedef enum logic [1:0] {
        ROT_0,
        ROT_90,
        ROT_180,
        ROT_270
    } t_rot;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_REM,
        S_ISSUE,
        S_LAST,
        S_PUT
    } t_bstate;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   idx;
        logic [BYTE_W-1:0]  data;
    } t_op;

    typedef struct packed {
        logic idle;
        logic put;
    } t_bstat;

endpackage

>>> rtl/brf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_front
// Takes requests, checks them against the image size, drops loads that fall
// outside it and sorts the rest into loads, reads and reads outside the image.
// ----------------------------------------------------------------------------
module brf_front
    import brf_pkg::*;
#(
    parameter int IMAGE_DIM = 64
) (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [IDX_W-1:0]  i_byte_index,
    input  logic [BYTE_W-1:0] i_src_byte,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output t_op               o_push_op
);

    localparam int STRIDE      = (IMAGE_DIM + 7) / 8;
    localparam int IMAGE_BYTES = STRIDE * IMAGE_DIM;

    logic w_in_image;
    logic w_drop;

    assign w_in_image = ({1'b0, i_byte_index} < (IDX_W + 1)'(IMAGE_BYTES));
    // loads outside the image are swallowed here
    assign w_drop     = (i_req_type == REQ_LOAD) && !w_in_image;

    always_comb begin
        o_push_op.idx  = i_byte_index;
        o_push_op.data = i_src_byte;
        if (i_req_type == REQ_LOAD) begin
            o_push_op.kind = K_LOAD;
        end else if (w_in_image) begin
            o_push_op.kind = K_READ;
        end else begin
            o_push_op.kind = K_ZERO;
        end
    end

    assign o_push_valid = i_in_valid && !w_drop;
    assign o_in_ready   = i_push_ready || w_drop;

endmodule

>>> rtl/brf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_queue
// Two-entry request queue between the front and the back end.
// ----------------------------------------------------------------------------
module brf_queue
    import brf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_op  i_push_op,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_op  o_pop_op
);

    t_op                r_slot [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_count;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_op     = r_slot[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wptr] <= i_push_op;
        end
    end

endmodule

>>> rtl/brf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_back
// Holds the source image and builds each destination byte one pixel per
// cycle through the single read port of the image memory.
// ----------------------------------------------------------------------------
module brf_back
    import brf_pkg::*;
#(
    parameter int IMAGE_DIM = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [XFORM_W-1:0] i_transform,
    input  logic               i_pop_valid,
    output logic               o_pop_ready,
    input  t_op                i_pop_op,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [BYTE_W-1:0]  o_dst_byte,
    output t_bstat             o_stat
);

    localparam int STRIDE      = (IMAGE_DIM + 7) / 8;
    localparam int IMAGE_BYTES = STRIDE * IMAGE_DIM;
    localparam int ADDR_W      = $clog2(IMAGE_BYTES);
    localparam int MEM_DEPTH   = 1 << ADDR_W;
    localparam int CW          = $clog2(STRIDE * 8);
    localparam int RECIP       = ((1 << DIV_SHIFT) + STRIDE - 1) / STRIDE;
    localparam int PROD_W      = IDX_W + DIV_SHIFT + 1;

    t_bstate             r_state;
    t_bstate             n_state;
    logic [BYTE_W-1:0]   r_mem [MEM_DEPTH];
    logic [BYTE_W-1:0]   r_rdata;
    logic [IDX_W-1:0]    r_idx;
    logic [CW-1:0]       r_dy;
    logic [CW-1:0]       r_col;
    logic [2:0]          r_bit;
    logic [2:0]          r_pos;
    logic [2:0]          r_sel;
    logic                r_pix;
    logic                r_pend;
    logic [BYTE_W-1:0]   r_acc;
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_dst;

    logic                w_pop;
    logic                w_out_free;
    logic [PROD_W-1:0]   w_prod;
    logic [IDX_W-1:0]    w_rem_full;
    logic [CW-1:0]       w_lim;
    logic [CW-1:0]       w_dx;
    logic [CW-1:0]       w_rx;
    logic [CW-1:0]       w_sx;
    logic [CW-1:0]       w_sy;
    logic                w_pix_ok;
    logic [ADDR_W-1:0]   w_addr;
    t_rot                w_rot;

    assign o_pop_ready = (r_state == S_IDLE);
    assign w_pop       = i_pop_valid && o_pop_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // row and byte column split of the request index
    assign w_prod     = PROD_W'(r_idx) * PROD_W'(RECIP);
    assign w_rem_full = r_idx - IDX_W'(IDX_W'(r_dy) * IDX_W'(STRIDE));

    // destination pixel to source pixel
    assign w_lim    = CW'(IMAGE_DIM - 1);
    assign w_dx     = r_col + CW'(r_bit);
    assign w_pix_ok = ({1'b0, w_dx} < (CW + 1)'(IMAGE_DIM));
    assign w_rx     = i_transform[FLIP_BIT] ? (w_lim - w_dx) : w_dx;
    assign w_rot    = t_rot'(i_transform[1:0]);

    always_comb begin
        unique case (w_rot)
            ROT_0: begin
                w_sx = w_rx;
                w_sy = r_dy;
            end
            ROT_90: begin
                w_sx = r_dy;
                w_sy = w_lim - w_rx;
            end
            ROT_180: begin
                w_sx = w_lim - w_rx;
                w_sy = w_lim - r_dy;
            end
            ROT_270: begin
                w_sx = w_lim - r_dy;
                w_sy = w_rx;
            end
            default: begin
                w_sx = w_rx;
                w_sy = r_dy;
            end
        endcase
    end

    assign w_addr = ADDR_W'(ADDR_W'(w_sy) * ADDR_W'(STRIDE) + ADDR_W'(w_sx >> 3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_pop && i_pop_op.kind == K_READ) begin
                    n_state = S_DIV;
                end else if (w_pop && i_pop_op.kind == K_ZERO) begin
                    n_state = S_PUT;
                end
            end
            S_DIV:   n_state = S_REM;
            S_REM:   n_state = S_ISSUE;
            S_ISSUE: begin
                if (r_bit == 3'd7) begin
                    n_state = S_LAST;
                end
            end
            S_LAST:  n_state = S_PUT;
            S_PUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && i_pop_op.kind == K_LOAD) begin
            r_mem[i_pop_op.idx[ADDR_W-1:0]] <= i_pop_op.data;
        end
        r_rdata <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= (r_state == S_ISSUE);
            if (r_state == S_PUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_idx <= i_pop_op.idx;
            r_acc <= '0;
        end
        if (r_state == S_DIV) begin
            r_dy <= CW'(w_prod >> DIV_SHIFT);
        end
        if (r_state == S_REM) begin
            r_col <= CW'({w_rem_full[2:0], 3'b000});
            r_bit <= '0;
            r_acc <= '0;
        end
        if (r_state == S_ISSUE) begin
            r_bit <= r_bit + 1'b1;
        end
        r_pos <= r_bit;
        r_sel <= w_sx[2:0];
        r_pix <= w_pix_ok;
        if (r_pend) begin
            r_acc[r_pos] <= r_pix & r_rdata[r_sel];
        end
        if (r_state == S_PUT && w_out_free) begin
            r_dst <= r_acc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_dst_byte  = r_dst;
    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.put  = (r_state == S_PUT) && w_out_free;

endmodule

>>> rtl/bitmap_rotate_flip_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_rotate_flip_top
// Square one-bit image store that returns bytes of the image turned by a
// multiple of 90 degrees and optionally mirrored left to right.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and are carried out one at a time by the
// back end. A load is written into the image memory as it leaves the queue.
// A read, once it leaves the queue, splits the index into row and byte
// column (a multiply by a reciprocal for the row, then the remainder),
// reads the eight pixels in turn, each a separate read on the one read port
// of the image memory, collects the last pixel and loads the output register
// once that register is free. A read outside the image goes straight to
// loading the output register and returns zero. The transform register sits
// at byte address 0 of the configuration port.
module bitmap_rotate_flip_top
    import brf_pkg::*;
#(
    parameter int IMAGE_DIM = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_req_type,
    input  logic [IDX_W-1:0]   i_byte_index,
    input  logic [BYTE_W-1:0]  i_src_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [BYTE_W-1:0]  o_dst_byte,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [XFORM_W-1:0] r_transform;
    logic               w_cfg_wr;
    logic               w_push_valid;
    logic               w_push_ready;
    t_op                w_push_op;
    logic               w_pop_valid;
    logic               w_pop_ready;
    t_op                w_pop_op;
    t_bstat             w_bstat;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transform <= '0;
        end else if (w_cfg_wr && paddr[2] == REG_TRANSFORM) begin
            r_transform <= pwdata[XFORM_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_TRANSFORM) begin
            prdata = PDATA_W'(r_transform);
        end
    end

    brf_front #(
        .IMAGE_DIM(IMAGE_DIM)
    ) u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_byte_index(i_byte_index),
        .i_src_byte  (i_src_byte),
        .o_push_valid(w_push_valid),
        .i_push_ready(w_push_ready),
        .o_push_op   (w_push_op)
    );

    brf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(w_push_valid),
        .o_push_ready(w_push_ready),
        .i_push_op   (w_push_op),
        .o_pop_valid (w_pop_valid),
        .i_pop_ready (w_pop_ready),
        .o_pop_op    (w_pop_op)
    );

    brf_back #(
        .IMAGE_DIM(IMAGE_DIM)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_transform(r_transform),
        .i_pop_valid(w_pop_valid),
        .o_pop_ready(w_pop_ready),
        .i_pop_op   (w_pop_op),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_dst_byte (o_dst_byte),
        .o_stat     (w_bstat)
    );

    // writes beyond the transform register leave it alone
    a_cfg_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && paddr[2] != REG_TRANSFORM) |=> $stable(r_transform))
        else $error("transform changed by write to another address");

    // a full queue always has something to hand to the back end
    a_queue_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_push_ready |-> w_pop_valid)
        else $error("queue full but empty");

    // a result appears only after the back end finishes a read
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_bstat.put))
        else $error("result without a finished read");

    // the back end takes requests only while idle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop_valid && w_pop_ready) |-> w_bstat.idle)
        else $error("request taken while back end busy");

endmodule
